### design/seconds_to_date_time_text_macros.svh
// Assertion macros for the seconds-to-date-time text block.
`ifndef SECONDS_TO_DATE_TIME_TEXT_MACROS_SVH
`define SECONDS_TO_DATE_TIME_TEXT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define STDT_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define STDT_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/stdt_pkg.sv
// Package: types, constants and helpers for the seconds-to-date-time text block.
`default_nettype none
package stdt_pkg;

    localparam int MONTH_COUNT = 12;

    localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
    localparam logic [11:0] SECS_PER_HOUR = 12'd3600;
    localparam logic [5:0]  SECS_PER_MIN  = 6'd60;
    localparam logic [8:0]  DAYS_IN_YEAR  = 9'd365;
    localparam logic [7:0]  ASCII_ZERO    = 8'h30;

    // Reciprocals (floored) for division by constants; estimates are low by at most one.
    // 86400 = 128 * 675, 3600 = 16 * 225, 60 = 4 * 15
    localparam int          DAY_SHIFT  = 28;
    localparam logic [18:0] DAY_RECIP  = 19'((1 << DAY_SHIFT) / 675);
    localparam int          HOUR_SHIFT = 20;
    localparam logic [12:0] HOUR_RECIP = 13'((1 << HOUR_SHIFT) / 225);
    localparam int          MIN_SHIFT  = 14;
    localparam logic [10:0] MIN_RECIP  = 11'((1 << MIN_SHIFT) / 15);

    localparam logic [8:0] MONTH_FIRST_DAY [MONTH_COUNT] = '{
        9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
        9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
    };

    typedef struct packed {
        logic [8:0]  days;
        logic [16:0] sec_of_day;
    } day_split_t;

    typedef struct packed {
        logic       out_of_range;
        logic [3:0] month;
        logic [4:0] day_of_month;
        logic [4:0] hour;
        logic [5:0] minute_est;
        logic [6:0] second_est;
    } clock_split_t;

    function automatic logic [23:0] month_letters(input logic [3:0] idx);
        logic [23:0] r;
        case (idx)
            4'd0:    r = 24'h4A414E;
            4'd1:    r = 24'h464542;
            4'd2:    r = 24'h4D4152;
            4'd3:    r = 24'h415052;
            4'd4:    r = 24'h4D4159;
            4'd5:    r = 24'h4A554E;
            4'd6:    r = 24'h4A554C;
            4'd7:    r = 24'h415547;
            4'd8:    r = 24'h534550;
            4'd9:    r = 24'h4F4354;
            4'd10:   r = 24'h4E4F56;
            4'd11:   r = 24'h444543;
            default: r = 24'h000000;
        endcase
        return r;
    endfunction

    // Two ASCII digits of a value below 100; tens = (v * 205) >> 11.
    function automatic logic [15:0] two_digits(input logic [6:0] v);
        logic [14:0] p;
        logic [3:0]  tens;
        logic [3:0]  ones;
        p    = 15'(v) * 15'd205;
        tens = p[14:11];
        ones = 4'(v - 7'(tens) * 7'd10);
        return {ASCII_ZERO + 8'(tens), ASCII_ZERO + 8'(ones)};
    endfunction

endpackage
`default_nettype wire

### design/stdt_day_div.sv
// Three-stage split of the seconds count into whole days and seconds of day.
`default_nettype none
module stdt_day_div import stdt_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        adv,
    input  wire logic        in_valid,
    input  wire logic [24:0] in_secs,
    output logic             out_valid,
    output day_split_t       out_data
);

    logic        v1_reg, v2_reg, v3_reg;
    logic [24:0] secs1_reg;
    logic [36:0] prod1_reg, prod1_next;
    logic [8:0]  q2_reg, q2_next;
    logic [17:0] rem2_reg, rem2_next;
    day_split_t  d3_reg, d3_next;

    always_comb begin
        prod1_next = 37'(in_secs[24:7]) * 37'(DAY_RECIP);
        q2_next    = prod1_reg[DAY_SHIFT +: 9];
        rem2_next  = 18'(26'(secs1_reg) - 26'(q2_next) * 26'(SECS_PER_DAY));
        if (rem2_reg >= 18'(SECS_PER_DAY)) begin
            d3_next.days       = q2_reg + 9'd1;
            d3_next.sec_of_day = 17'(rem2_reg - 18'(SECS_PER_DAY));
        end else begin
            d3_next.days       = q2_reg;
            d3_next.sec_of_day = rem2_reg[16:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            secs1_reg <= in_secs;
            prod1_reg <= prod1_next;
            q2_reg    <= q2_next;
            rem2_reg  <= rem2_next;
            d3_reg    <= d3_next;
        end
    end

    assign out_valid = v3_reg;
    assign out_data  = d3_reg;

endmodule
`default_nettype wire

### design/stdt_clock_div.sv
// Four-stage split into month, day of month, hour, minute and second estimates.
`default_nettype none
module stdt_clock_div import stdt_pkg::*; (
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire logic   adv,
    input  wire logic   in_valid,
    input  wire day_split_t in_data,
    output logic        out_valid,
    output clock_split_t out_data
);

    logic         v4_reg, v5_reg, v6_reg, v7_reg;
    logic [25:0]  hprod4_reg, hprod4_next;
    logic [16:0]  sod4_reg;
    logic [8:0]   days4_reg;
    logic [3:0]   month4_reg, month4_next;

    logic [4:0]   hest5;
    logic [12:0]  remh5_reg, remh5_next;
    logic [4:0]   hest5_reg;
    logic [3:0]   month5_reg;
    logic [4:0]   dom5_reg, dom5_next;
    logic         oor5_reg, oor5_next;

    logic [4:0]   hour6_reg, hour6_next;
    logic [11:0]  rem6_reg, rem6_next;
    logic [20:0]  mprod6_reg, mprod6_next;
    logic [3:0]   month6_reg;
    logic [4:0]   dom6_reg;
    logic         oor6_reg;

    logic [5:0]   mest7;
    clock_split_t c7_reg, c7_next;

    always_comb begin
        hprod4_next = 26'(in_data.sec_of_day[16:4]) * 26'(HOUR_RECIP);
        month4_next = 4'd0;
        for (int i = 1; i < MONTH_COUNT; i++) begin
            if (in_data.days >= MONTH_FIRST_DAY[i]) begin
                month4_next = 4'(i);
            end
        end
    end

    always_comb begin
        hest5      = hprod4_reg[HOUR_SHIFT +: 5];
        remh5_next = 13'(sod4_reg - 17'(hest5) * 17'(SECS_PER_HOUR));
        dom5_next  = 5'(days4_reg - MONTH_FIRST_DAY[month4_reg] + 9'd1);
        oor5_next  = (days4_reg >= DAYS_IN_YEAR);
    end

    always_comb begin
        if (remh5_reg >= 13'(SECS_PER_HOUR)) begin
            hour6_next = hest5_reg + 5'd1;
            rem6_next  = 12'(remh5_reg - 13'(SECS_PER_HOUR));
        end else begin
            hour6_next = hest5_reg;
            rem6_next  = remh5_reg[11:0];
        end
        mprod6_next = 21'(rem6_next[11:2]) * 21'(MIN_RECIP);
    end

    always_comb begin
        mest7                = mprod6_reg[MIN_SHIFT +: 6];
        c7_next.out_of_range = oor6_reg;
        c7_next.month        = month6_reg;
        c7_next.day_of_month = dom6_reg;
        c7_next.hour         = hour6_reg;
        c7_next.minute_est   = mest7;
        c7_next.second_est   = 7'(rem6_reg - 12'(mest7) * 12'(SECS_PER_MIN));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end else if (adv) begin
            v4_reg <= in_valid;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            hprod4_reg <= hprod4_next;
            sod4_reg   <= in_data.sec_of_day;
            days4_reg  <= in_data.days;
            month4_reg <= month4_next;
            hest5_reg  <= hest5;
            remh5_reg  <= remh5_next;
            month5_reg <= month4_reg;
            dom5_reg   <= dom5_next;
            oor5_reg   <= oor5_next;
            hour6_reg  <= hour6_next;
            rem6_reg   <= rem6_next;
            mprod6_reg <= mprod6_next;
            month6_reg <= month5_reg;
            dom6_reg   <= dom5_reg;
            oor6_reg   <= oor5_reg;
            c7_reg     <= c7_next;
        end
    end

    assign out_valid = v7_reg;
    assign out_data  = c7_reg;

endmodule
`default_nettype wire

### design/stdt_text_fmt.sv
// Final correction, ASCII formatting and the output register.
`default_nettype none
module stdt_text_fmt import stdt_pkg::*; (
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    adv,
    input  wire logic    in_valid,
    input  wire clock_split_t in_data,
    output logic         out_valid,
    output logic [87:0]  out_tdata,
    output logic         out_tuser
);

    logic        valid_reg;
    logic [87:0] tdata_reg, tdata_next;
    logic        tuser_reg;
    logic [5:0]  minute;
    logic [6:0]  second;

    always_comb begin
        if (in_data.second_est >= 7'(SECS_PER_MIN)) begin
            minute = in_data.minute_est + 6'd1;
            second = in_data.second_est - 7'(SECS_PER_MIN);
        end else begin
            minute = in_data.minute_est;
            second = in_data.second_est;
        end
        if (in_data.out_of_range) begin
            tdata_next = '0;
        end else begin
            tdata_next = {two_digits(second),
                          two_digits(7'(minute)),
                          two_digits(7'(in_data.hour)),
                          two_digits(7'(in_data.day_of_month)),
                          month_letters(in_data.month)};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            tdata_reg <= tdata_next;
            tuser_reg <= in_data.out_of_range;
        end
    end

    assign out_valid = valid_reg;
    assign out_tdata = tdata_reg;
    assign out_tuser = tuser_reg;

endmodule
`default_nettype wire

### design/seconds_to_date_time_text.sv
// Top level: seconds since start of a non-leap year to date and time ASCII text.
//
// Input stream: one transaction per timestamp, s_axis_tdata[24:0] holds the
// seconds count. Output stream: one transaction per input, carrying month
// letters and two-digit day, hour, minute and second text; m_axis_tuser flags
// a day count of 365 or more, with all text then zero.
// Throughput: one transaction per cycle while the output is not stalled. Pipeline
// from input accept to the output register: 3 stages day divide,
// 4 stages month and clock split, 1 stage formatting and output.
// Reset empties the pipeline; the valid bits clear, data is left as is.
// When the receiver stalls with a result pending, the whole pipeline holds and
// s_axis_tready drops in the same cycle; nothing is dropped or repeated.
// While the output register is empty or being taken, a new transaction is
// accepted every cycle.
`default_nettype none
`include "seconds_to_date_time_text_macros.svh"
module seconds_to_date_time_text import stdt_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // [24:0] seconds_count
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [87:0]      m_axis_tdata,   // month_text, day_text, hour_text,
                                             // minute_text, second_text
    output logic             m_axis_tuser    // out_of_range
);

    logic         adv;
    logic         day_valid;
    day_split_t   day_data;
    logic         clk_valid;
    clock_split_t clk_data;

    assign adv           = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = adv;

    stdt_day_div u_day_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (s_axis_tvalid),
        .in_secs   (s_axis_tdata[24:0]),
        .out_valid (day_valid),
        .out_data  (day_data)
    );

    stdt_clock_div u_clock_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (day_valid),
        .in_data   (day_data),
        .out_valid (clk_valid),
        .out_data  (clk_data)
    );

    stdt_text_fmt u_text_fmt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (clk_valid),
        .in_data   (clk_data),
        .out_valid (m_axis_tvalid),
        .out_tdata (m_axis_tdata),
        .out_tuser (m_axis_tuser)
    );

    `STDT_ASSERT_IMPL(a_oor_zero_text, aclk, aresetn, m_axis_tvalid && m_axis_tuser, m_axis_tdata == 88'd0, "out-of-range result carries nonzero text")
    `STDT_ASSERT_IMPL(a_day_tens, aclk, aresetn, m_axis_tvalid && !m_axis_tuser, m_axis_tdata[39:32] >= 8'h30 && m_axis_tdata[39:32] <= 8'h33, "day tens digit out of range")
    `STDT_ASSERT_IMPL(a_hour_tens, aclk, aresetn, m_axis_tvalid && !m_axis_tuser, m_axis_tdata[55:48] >= 8'h30 && m_axis_tdata[55:48] <= 8'h32, "hour tens digit out of range")
    `STDT_ASSERT_IMPL(a_ready_when_empty, aclk, aresetn, !m_axis_tvalid, s_axis_tready, "input not accepted with empty output")

endmodule
`default_nettype wire
